>>> rtl/core/linear_probe_hash_table_macros.svh
// Assertion macros for the linear-probe hash table.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
// No dependencies; compile first.
package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 256;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;

    localparam logic [KEY_W-1:0] HASH_MULT  = 32'h045d_9f3b;
    localparam int               HASH_SHIFT = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic used;
        logic tomb;
    } slot_flags_t;

endpackage

>>> rtl/core/lpht_if.sv
// Request and response channel interfaces for the linear-probe hash table.
// Depends on lpht_pkg for field widths.
interface lpht_req_if;
    logic                               valid;
    logic                               ready;
    logic        [lpht_pkg::CMD_W-1:0]  cmd;
    logic signed [lpht_pkg::KEY_W-1:0]  key;
    logic signed [lpht_pkg::DATA_W-1:0] value_in;

    modport source (output valid, cmd, key, value_in, input ready);
    modport sink   (input valid, cmd, key, value_in, output ready);
endinterface

interface lpht_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               ok;
    logic signed [lpht_pkg::DATA_W-1:0] value_out;

    modport source (output valid, ok, value_out, input ready);
    modport sink   (input valid, ok, value_out, output ready);
endinterface

>>> rtl/core/linear_probe_hash_table.sv
// Linear-probe hash table top level: hash unit, probe sequencer, slot memories.
// Depends on lpht_pkg, lpht_if.sv and linear_probe_hash_table_macros.svh.
//
//   channel  dir  payload                       handshake
//   -------  ---  ----------------------------  ---------------------
//   req      in   cmd, key, value_in            valid/ready, sink
//   rsp      out  ok, value_out                 valid/ready, source
//
// From one accept to the next an item passes through the hash, remainder and
// probe states; the remainder takes extra steps when TABLE_SLOTS is not a power
// of two. An item probes from 1 up to TABLE_SLOTS slots. The probe loop reads
// one slot per cycle from the slot memories. After reset a clearing pass zeroes
// the slot flags; req.ready stays low until it ends. A full result register
// stalls the probe sequencer at its last slot until rsp.ready frees it.
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    lpht_req_if.sink          req,
    lpht_rsp_if.source        rsp
);

    localparam int KW        = lpht_pkg::KEY_W;
    localparam int DW        = lpht_pkg::DATA_W;
    localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam bit IS_POW2   = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam int MOD_STEPS = 4;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [SLOT_W:0]      SLOTS_EXT = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0]     SLOTS_CNT = CNT_W'(TABLE_SLOTS);
    localparam logic [MOD_CNT_W-1:0] MOD_LAST  = MOD_CNT_W'(MOD_STEPS - 1);

    // Reciprocal floor(2^(KW+SLOT_W) / TABLE_SLOTS); fits in KW+1 bits.
    localparam logic [KW:0]   RECIP    =
        (KW + 1)'(((2 * KW + 1)'(1) << (KW + SLOT_W)) / TABLE_SLOTS);
    localparam logic [KW-1:0] RECIP_LO = RECIP[KW-1:0];
    localparam logic          RECIP_HI = RECIP[KW];

    // Slot memories: key/value pair and used/tombstone flags per slot.
    logic [KW+DW-1:0]      data_mem [TABLE_SLOTS];
    lpht_pkg::slot_flags_t flag_mem [TABLE_SLOTS];

    lpht_pkg::state_t state_reg, state_next;

    logic [lpht_pkg::CMD_W-1:0] cmd_reg;
    logic [KW-1:0]              key_reg;
    logic [DW-1:0]              val_reg;
    logic [KW-1:0]              prod_reg;
    logic [2*KW-1:0]            mprod_reg;
    logic [SLOT_W:0]            quot_reg;
    logic [SLOT_W:0]            qmul_reg;
    logic [MOD_CNT_W-1:0]       mod_cnt_reg;
    logic [SLOT_W-1:0]          probe_slot_reg;
    logic [SLOT_W-1:0]          probe_cnt_reg;
    logic                       have_free_reg;
    logic [SLOT_W-1:0]          free_slot_reg;
    logic [SLOT_W-1:0]          clr_cnt_reg;
    logic [CNT_W-1:0]           live_count_reg;
    logic                       out_valid_reg;
    logic                       out_ok_reg;
    logic [DW-1:0]              out_val_reg;

    logic [KW+DW-1:0]      rd_data_reg;
    lpht_pkg::slot_flags_t rd_flags_reg;

    // Hash and slot remainder
    logic [KW-1:0]     hash_val;
    logic [2*KW:0]     mprod_sum;
    logic [SLOT_W:0]   rem_raw;
    logic [SLOT_W:0]   rem_fix;
    logic [SLOT_W-1:0] home_slot;
    logic              mod_done;

    // Probe decision
    logic              used, free_here, live_hit, last_probe;
    logic              finish, out_free, commit;
    logic              res_ok;
    logic [DW-1:0]     res_val;
    logic              data_we, slot_flag_we;
    logic              flag_mem_we;
    logic [SLOT_W-1:0] flag_wr_addr;
    lpht_pkg::slot_flags_t slot_flag_data, flag_wr_data;
    logic [SLOT_W-1:0] wr_slot;
    logic              live_inc, live_dec;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] next_slot;

    assign req.ready     = (state_reg == lpht_pkg::ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = out_ok_reg;
    assign rsp.value_out = out_val_reg;

    // Shift-xor finish of the hash; the multiply sits in its own register.
    assign hash_val = prod_reg ^ (prod_reg >> lpht_pkg::HASH_SHIFT);

    // Remainder by reciprocal multiplication, one register per step while the
    // hash holds still: product, low quotient bits, quotient times slots, then
    // subtract and correct once. The estimated quotient is short by at most one.
    assign mprod_sum = {1'b0, mprod_reg} +
                       (RECIP_HI ? {1'b0, hash_val, {KW{1'b0}}} : '0);
    assign rem_raw   = hash_val[SLOT_W:0] - qmul_reg;
    assign rem_fix   = (rem_raw >= SLOTS_EXT) ? rem_raw - SLOTS_EXT : rem_raw;

    assign home_slot = IS_POW2 ? hash_val[SLOT_W-1:0] : rem_fix[SLOT_W-1:0];
    assign mod_done  = IS_POW2 || (mod_cnt_reg == MOD_LAST);

    assign next_slot  = (probe_slot_reg == LAST_SLOT) ? '0 : probe_slot_reg + 1'b1;
    assign used       = rd_flags_reg.used;
    assign free_here  = !rd_flags_reg.used || rd_flags_reg.tomb;
    assign live_hit   = rd_flags_reg.used && !rd_flags_reg.tomb &&
                        (rd_data_reg[KW+DW-1:DW] == key_reg);
    assign last_probe = (probe_cnt_reg == LAST_SLOT);
    assign out_free   = !out_valid_reg || rsp.ready;

    // Decide on the slot whose data sits in the read register.
    always_comb
    begin
        finish         = 1'b0;
        res_ok         = 1'b0;
        res_val        = '0;
        data_we        = 1'b0;
        slot_flag_we   = 1'b0;
        slot_flag_data = '{used: 1'b1, tomb: 1'b0};
        wr_slot        = probe_slot_reg;
        live_inc       = 1'b0;
        live_dec       = 1'b0;
        case (cmd_reg) inside
            lpht_pkg::CMD_INSERT:
            begin
                if (live_hit)
                begin
                    finish       = 1'b1;
                    res_ok       = 1'b1;
                    data_we      = 1'b1;
                    slot_flag_we = 1'b1;
                end
                else if (!used || last_probe)
                begin
                    finish = 1'b1;
                    if (have_free_reg || free_here)
                    begin
                        res_ok       = 1'b1;
                        data_we      = 1'b1;
                        slot_flag_we = 1'b1;
                        live_inc     = 1'b1;
                        wr_slot      = have_free_reg ? free_slot_reg : probe_slot_reg;
                    end
                end
            end
            lpht_pkg::CMD_GET, lpht_pkg::CMD_DELETE:
            begin
                if (!used)
                begin
                    finish = 1'b1;
                end
                else if (live_hit)
                begin
                    finish = 1'b1;
                    res_ok = 1'b1;
                    if (cmd_reg == lpht_pkg::CMD_GET)
                    begin
                        res_val = rd_data_reg[DW-1:0];
                    end
                    else
                    begin
                        slot_flag_we   = 1'b1;
                        slot_flag_data = '{used: 1'b1, tomb: 1'b1};
                        live_dec       = 1'b1;
                    end
                end
                else if (last_probe)
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                finish = 1'b1;
            end
        endcase
    end

    assign commit = (state_reg == lpht_pkg::ST_PROBE) && finish && out_free;

    // Read port: home slot when the remainder lands, then one slot per cycle.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = next_slot;
        if (state_reg == lpht_pkg::ST_MOD && mod_done)
        begin
            rd_en   = 1'b1;
            rd_addr = home_slot;
        end
        else if (state_reg == lpht_pkg::ST_PROBE && !finish)
        begin
            rd_en = 1'b1;
        end
    end

    // Flag write port shared by the clearing pass and the probe commit.
    always_comb
    begin
        if (state_reg == lpht_pkg::ST_CLEAR)
        begin
            flag_mem_we  = 1'b1;
            flag_wr_addr = clr_cnt_reg;
            flag_wr_data = '{used: 1'b0, tomb: 1'b0};
        end
        else
        begin
            flag_mem_we  = commit && slot_flag_we;
            flag_wr_addr = wr_slot;
            flag_wr_data = slot_flag_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= data_mem[rd_addr];
            rd_flags_reg <= flag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && data_we)
        begin
            data_mem[wr_slot] <= {key_reg, val_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_mem_we)
        begin
            flag_mem[flag_wr_addr] <= flag_wr_data;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpht_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            lpht_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = lpht_pkg::ST_HASH;
                end
            end
            lpht_pkg::ST_HASH:
            begin
                state_next = lpht_pkg::ST_MOD;
            end
            lpht_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = lpht_pkg::ST_PROBE;
                end
            end
            lpht_pkg::ST_PROBE:
            begin
                if (finish && out_free)
                begin
                    state_next = lpht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lpht_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            mod_cnt_reg    <= '0;
            probe_cnt_reg  <= '0;
            have_free_reg  <= 1'b0;
            live_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lpht_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == lpht_pkg::ST_MOD)
            begin
                mod_cnt_reg <= mod_done ? '0 : mod_cnt_reg + 1'b1;
                if (mod_done)
                begin
                    probe_cnt_reg <= '0;
                    have_free_reg <= 1'b0;
                end
            end
            if (state_reg == lpht_pkg::ST_PROBE && !finish)
            begin
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
                if (free_here)
                begin
                    have_free_reg <= 1'b1;
                end
            end
            if (commit && live_inc)
            begin
                live_count_reg <= live_count_reg + 1'b1;
            end
            else if (commit && live_dec && live_count_reg != '0)
            begin
                live_count_reg <= live_count_reg - 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg <= req.cmd;
            key_reg <= req.key;
            val_reg <= req.value_in;
        end
        if (state_reg == lpht_pkg::ST_HASH)
        begin
            prod_reg <= (key_reg ^ (key_reg >> lpht_pkg::HASH_SHIFT)) * lpht_pkg::HASH_MULT;
        end
        if (state_reg == lpht_pkg::ST_MOD)
        begin
            // Each step settles in the cycle after the one before it.
            mprod_reg <= (2 * KW)'(hash_val) * (2 * KW)'(RECIP_LO);
            quot_reg  <= mprod_sum[KW + 2 * SLOT_W -: SLOT_W + 1];
            qmul_reg  <= quot_reg * SLOTS_EXT;
            if (mod_done)
            begin
                probe_slot_reg <= home_slot;
            end
        end
        if (state_reg == lpht_pkg::ST_PROBE && !finish)
        begin
            probe_slot_reg <= next_slot;
            if (free_here && !have_free_reg)
            begin
                free_slot_reg <= probe_slot_reg;
            end
        end
        if (commit)
        begin
            out_ok_reg  <= res_ok;
            out_val_reg <= res_val;
        end
    end

    // Assertions
    `LPHT_ASSERT_NOW(a_live_bound, 1'b1, live_count_reg <= SLOTS_CNT, "live count exceeds slots")
    `LPHT_ASSERT_NEXT(a_accept_hash, req.valid && req.ready, state_reg == lpht_pkg::ST_HASH, "accepted item did not start hashing")
    `LPHT_ASSERT_NOW(a_result_from_probe, out_valid_reg && !$past(out_valid_reg), $past(state_reg) == lpht_pkg::ST_PROBE, "result appeared outside probe")

endmodule
